// ===== rtl/lmsr_pkg.sv =====
package lmsr_pkg;

    localparam int PAIR_SLOTS_DEF    = 16;
    localparam int MAX_KEY_LEN_DEF   = 8;
    localparam int MAX_VALUE_LEN_DEF = 8;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // write the pair slot from the held item
        logic push;      // append the held subject byte to the window
        logic resolve;   // latch the match result for the window head
        logic emit;      // not set by the controller and not read by the datapath
        logic advance;   // step the emit counter
        logic drop;      // remove the matched bytes from the window
        logic stash;     // keep the current output byte in the hold register
        logic use_held;  // send the hold register instead of the current byte
    } lmsr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_data;
        logic is_last;
        logic win_full;
        logic win_empty;
        logic emit_more;   // at least one byte left to emit for this position
        logic emit_final;  // the byte in flight is the last of this position
    } lmsr_stat_t;

endpackage

// ===== rtl/lmsr_if.sv =====
interface lmsr_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  slot;
    logic [63:0] key_bytes;
    logic [3:0]  key_length;
    logic [63:0] value_bytes;
    logic [3:0]  value_length;
    logic [7:0]  data_byte;
    logic        last_byte;

    modport source (output valid, func, slot, key_bytes, key_length, value_bytes,
                    value_length, data_byte, last_byte, input ready);
    modport sink (input valid, func, slot, key_bytes, key_length, value_bytes,
                  value_length, data_byte, last_byte, output ready);
endinterface

interface lmsr_out_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, byte_valid, out_byte, run_last, string_end,
                    input ready);
    modport sink (input valid, byte_valid, out_byte, run_last, string_end,
                  output ready);
endinterface

// ===== rtl/lmsr_datapath.sv =====
module lmsr_datapath #(
    parameter int PAIR_SLOTS    = lmsr_pkg::PAIR_SLOTS_DEF,
    parameter int MAX_KEY_LEN   = lmsr_pkg::MAX_KEY_LEN_DEF,
    parameter int MAX_VALUE_LEN = lmsr_pkg::MAX_VALUE_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                capture,
    input  logic                in_func,
    input  logic [3:0]          in_slot,
    input  logic [63:0]         in_key_bytes,
    input  logic [3:0]          in_key_length,
    input  logic [63:0]         in_value_bytes,
    input  logic [3:0]          in_value_length,
    input  logic [7:0]          in_data_byte,
    input  logic                in_last_byte,
    input  lmsr_pkg::lmsr_cmd_t cmd,
    output lmsr_pkg::lmsr_stat_t stat,
    output logic [7:0]          emit_byte
);
    import lmsr_pkg::*;

    localparam int SW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int KW = $clog2(MAX_KEY_LEN + 1);
    localparam int VW = $clog2(MAX_VALUE_LEN + 1);
    localparam int WW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int EW = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;

    // Held input item.
    logic        func_reg;
    logic [3:0]  slot_reg;
    logic [63:0] key_reg;
    logic [3:0]  klen_reg;
    logic [63:0] val_reg;
    logic [3:0]  vlen_reg;
    logic [7:0]  data_reg;
    logic        last_reg;

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            func_reg <= in_func;
            slot_reg <= in_slot;
            key_reg  <= in_key_bytes;
            klen_reg <= in_key_length;
            val_reg  <= in_value_bytes;
            vlen_reg <= in_value_length;
            data_reg <= in_data_byte;
            last_reg <= in_last_byte;
        end
    end

    // Pair table; key lengths reset to zero so every slot starts unused.
    logic [8*MAX_KEY_LEN-1:0]   keys_reg [PAIR_SLOTS];
    logic [KW-1:0]              klens_reg [PAIR_SLOTS];
    logic [8*MAX_VALUE_LEN-1:0] vals_reg [PAIR_SLOTS];
    logic [VW-1:0]              vlens_reg [PAIR_SLOTS];

    logic          slot_ok;
    logic [KW-1:0] load_klen;
    logic [VW-1:0] load_vlen;

    always_comb
    begin
        slot_ok   = ({28'd0, slot_reg} < 32'(PAIR_SLOTS));
        load_klen = (klen_reg > 4'(MAX_KEY_LEN)) ? '0 : KW'(klen_reg);
        load_vlen = (vlen_reg > 4'(MAX_VALUE_LEN)) ? VW'(MAX_VALUE_LEN) : VW'(vlen_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < PAIR_SLOTS; s++)
            begin
                klens_reg[s] <= '0;
            end
        end
        else if (cmd.load && slot_ok)
        begin
            klens_reg[SW'(slot_reg)] <= load_klen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            keys_reg[SW'(slot_reg)]  <= key_reg[8*MAX_KEY_LEN-1:0];
            vals_reg[SW'(slot_reg)]  <= val_reg[8*MAX_VALUE_LEN-1:0];
            vlens_reg[SW'(slot_reg)] <= load_vlen;
        end
    end

    // Lookahead window as a shift line with a fill count.
    logic [7:0]    win_reg [MAX_KEY_LEN];
    logic [KW-1:0] fill_reg, fill_next;
    logic [KW-1:0] best_len_reg;
    logic [SW-1:0] best_slot_reg;
    logic [EW-1:0] eidx_reg;
    logic [7:0]    held_reg;
    logic [7:0]    cur_byte;

    // Match of every slot against the window head, in parallel.
    logic [KW-1:0] best_len;
    logic [SW-1:0] best_slot;

    always_comb
    begin
        logic ok;
        best_len  = '0;
        best_slot = '0;
        for (int s = 0; s < PAIR_SLOTS; s++)
        begin
            ok = (klens_reg[s] != '0) && (klens_reg[s] <= fill_reg)
                 && (klens_reg[s] > best_len);
            for (int i = 0; i < MAX_KEY_LEN; i++)
            begin
                if (KW'(i) < klens_reg[s] && keys_reg[s][8*i +: 8] != win_reg[i])
                begin
                    ok = 1'b0;
                end
            end
            if (ok)
            begin
                best_len  = klens_reg[s];
                best_slot = SW'(s);
            end
        end
    end

    logic [VW-1:0] cur_vlen;
    logic [KW-1:0] drop_cnt;

    always_comb
    begin
        cur_vlen = (best_len_reg == '0) ? VW'(1) : vlens_reg[best_slot_reg];
        drop_cnt = (best_len_reg == '0) ? KW'(1) : best_len_reg;
        fill_next = fill_reg;
        if (cmd.push && fill_reg < KW'(MAX_KEY_LEN))
        begin
            fill_next = fill_reg + KW'(1);
        end
        else if (cmd.drop)
        begin
            fill_next = (drop_cnt >= fill_reg) ? '0 : fill_reg - drop_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            eidx_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (cmd.resolve)
            begin
                eidx_reg <= '0;
            end
            else if (cmd.advance)
            begin
                eidx_reg <= eidx_reg + EW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            best_len_reg  <= best_len;
            best_slot_reg <= best_slot;
        end
        if (cmd.stash)
        begin
            held_reg <= cur_byte;
        end
        if (cmd.push && fill_reg < KW'(MAX_KEY_LEN))
        begin
            win_reg[WW'(fill_reg)] <= data_reg;
        end
        else if (cmd.drop)
        begin
            for (int i = 0; i < MAX_KEY_LEN; i++)
            begin
                if (i + int'(drop_cnt) < MAX_KEY_LEN)
                begin
                    win_reg[i] <= win_reg[i + int'(drop_cnt)];
                end
            end
        end
    end

    // Output byte selection and status.
    always_comb
    begin
        if (best_len_reg == '0)
        begin
            cur_byte = win_reg[0];
        end
        else
        begin
            cur_byte = vals_reg[best_slot_reg][8*eidx_reg +: 8];
        end
        emit_byte       = cmd.use_held ? held_reg : cur_byte;
        stat.is_data    = (func_reg == FUNC_DATA);
        stat.is_last    = last_reg;
        stat.win_full   = (fill_reg >= KW'(MAX_KEY_LEN));
        stat.win_empty  = (fill_reg == '0);
        stat.emit_more  = ({{(32-VW){1'b0}}, cur_vlen} > {{(32-EW){1'b0}}, eidx_reg});
        stat.emit_final = ({{(32-VW){1'b0}}, cur_vlen} == {{(32-EW){1'b0}}, eidx_reg} + 32'd1);
    end

endmodule

// ===== rtl/lmsr_ctrl.sv =====
module lmsr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 capture,
    input  lmsr_pkg::lmsr_stat_t stat,
    output lmsr_pkg::lmsr_cmd_t  cmd,
    output logic                 emit_valid,
    output logic                 emit_run_last,
    output logic                 emit_end,
    output logic                 emit_blank,
    input  logic                 emit_ready
);
    import lmsr_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_DECODE  = 7'b0000010,
        ST_RESOLVE = 7'b0000100,
        ST_EMIT    = 7'b0001000,
        ST_NEXT    = 7'b0010000,
        ST_BLANK   = 7'b0100000,
        ST_TAIL    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    // A byte has been produced for this item; on a final byte it sits in the
    // hold register until the next one shows it is not the last.
    logic   any_reg, any_next;

    always_comb
    begin
        state_next    = state_reg;
        any_next      = any_reg;
        cmd           = '0;
        in_ready      = 1'b0;
        capture       = 1'b0;
        emit_valid    = 1'b0;
        emit_run_last = 1'b0;
        emit_end      = 1'b0;
        emit_blank    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    capture    = 1'b1;
                    any_next   = 1'b0;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                if (!stat.is_data)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.push = 1'b1;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                // Decide whether a position is resolved now.
                if (stat.is_last ? !stat.win_empty : stat.win_full)
                begin
                    state_next = ST_RESOLVE;
                end
                else if (stat.is_last)
                begin
                    state_next = any_reg ? ST_TAIL : ST_BLANK;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!stat.emit_more)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_NEXT;
                end
                else if (stat.is_last && !any_reg)
                begin
                    // The first byte of a flush waits in the hold register.
                    cmd.stash   = 1'b1;
                    cmd.advance = 1'b1;
                    any_next    = 1'b1;
                    if (stat.emit_final)
                    begin
                        cmd.drop   = 1'b1;
                        state_next = ST_NEXT;
                    end
                end
                else
                begin
                    // During a flush the held byte goes out and the new one waits.
                    emit_valid   = 1'b1;
                    cmd.use_held = stat.is_last;
                    if (stat.emit_final && !stat.is_last)
                    begin
                        emit_run_last = 1'b1;
                    end
                    if (emit_ready)
                    begin
                        cmd.advance = 1'b1;
                        cmd.stash   = stat.is_last;
                        any_next    = 1'b1;
                        if (stat.emit_final)
                        begin
                            cmd.drop   = 1'b1;
                            state_next = ST_NEXT;
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                // The held byte is the last of the rewritten string.
                emit_valid    = 1'b1;
                cmd.use_held  = 1'b1;
                emit_run_last = 1'b1;
                emit_end      = 1'b1;
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BLANK:
            begin
                emit_valid    = 1'b1;
                emit_blank    = 1'b1;
                emit_run_last = 1'b1;
                emit_end      = 1'b1;
                if (emit_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            any_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            any_reg   <= any_next;
        end
    end

endmodule

// ===== rtl/lmsr_outbuf.sv =====
module lmsr_outbuf (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       emit_valid,
    output logic       emit_ready,
    input  logic       byte_valid,
    input  logic [7:0] out_byte,
    input  logic       run_last,
    input  logic       string_end,
    lmsr_out_if.source res
);
    // Single output register; refills in the cycle it is taken.
    logic       valid_reg;
    logic       bv_reg;
    logic [7:0] byte_reg;
    logic       rl_reg;
    logic       se_reg;

    assign emit_ready = !valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (emit_ready)
        begin
            valid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_ready && emit_valid)
        begin
            bv_reg   <= byte_valid;
            byte_reg <= out_byte;
            rl_reg   <= run_last;
            se_reg   <= string_end;
        end
    end

    assign res.valid      = valid_reg;
    assign res.byte_valid = bv_reg;
    assign res.out_byte   = byte_reg;
    assign res.run_last   = rl_reg;
    assign res.string_end = se_reg;

endmodule

// ===== rtl/longest_match_string_replace_top.sv =====
// Longest-match string replacement. Load items (func 0) write a key/value pair
// into a slot; subject items (func 1) push one byte into an eight-byte lookahead
// window. When the window is full, or on the final byte until it is empty, all
// slots are compared against the window head in parallel and the longest match
// (lowest slot on ties) is replaced by its value, else the head byte passes.
// Items are taken one at a time: the input is ready only while the block is idle.
// A load item is captured, then written to its slot. A subject item is captured
// and pushed; each resolved position is latched, its output bytes sent and its
// matched bytes dropped; a final byte adds a result that closes the string.
// Output bytes leave through a single output register, one a cycle while it is
// free or taken, and the block stalls while it is full and not taken. A final
// byte yielding nothing returns one result with byte_valid 0 marking the end.
module longest_match_string_replace_top #(
    parameter int PAIR_SLOTS    = lmsr_pkg::PAIR_SLOTS_DEF,
    parameter int MAX_KEY_LEN   = lmsr_pkg::MAX_KEY_LEN_DEF,
    parameter int MAX_VALUE_LEN = lmsr_pkg::MAX_VALUE_LEN_DEF
) (
    input logic        clk,
    input logic        rst_n,
    lmsr_in_if.sink    req,
    lmsr_out_if.source res
);
    import lmsr_pkg::*;

    lmsr_cmd_t  cmd;
    lmsr_stat_t stat;
    logic       capture;
    logic [7:0] emit_byte;
    logic       emit_valid, emit_ready, emit_run_last, emit_end, emit_blank;
    logic       rdy;

    assign req.ready = rdy;

    lmsr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (req.valid),
        .in_ready      (rdy),
        .capture       (capture),
        .stat          (stat),
        .cmd           (cmd),
        .emit_valid    (emit_valid),
        .emit_run_last (emit_run_last),
        .emit_end      (emit_end),
        .emit_blank    (emit_blank),
        .emit_ready    (emit_ready)
    );

    lmsr_datapath #(
        .PAIR_SLOTS    (PAIR_SLOTS),
        .MAX_KEY_LEN   (MAX_KEY_LEN),
        .MAX_VALUE_LEN (MAX_VALUE_LEN)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .capture         (capture),
        .in_func         (req.func),
        .in_slot         (req.slot),
        .in_key_bytes    (req.key_bytes),
        .in_key_length   (req.key_length),
        .in_value_bytes  (req.value_bytes),
        .in_value_length (req.value_length),
        .in_data_byte    (req.data_byte),
        .in_last_byte    (req.last_byte),
        .cmd             (cmd),
        .stat            (stat),
        .emit_byte       (emit_byte)
    );

    lmsr_outbuf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .byte_valid (!emit_blank),
        .out_byte   (emit_blank ? 8'd0 : emit_byte),
        .run_last   (emit_run_last),
        .string_end (emit_end),
        .res        (res)
    );

endmodule
